@@ design/mwcd_pkg.sv @@
// Package for the multi-window customer dispatcher.
// Holds the request and result payload types, register indexes, codes and FSM states.
// No dependencies.
package mwcd_pkg;

   // Field widths
   localparam int MINUTE_W  = 12;
   localparam int SERVICE_W = 8;
   localparam int WINDOW_W  = 3;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 12;
   localparam int USED_W    = 4;

   // Parameter defaults
   localparam int DEFAULT_WINDOWS     = 8;
   localparam int DEFAULT_QUEUE_DEPTH = 16;

   // Register reset values and the minute saturation limit
   localparam logic              MODE_RESET    = 1'b0;
   localparam logic [USED_W-1:0] USED_RESET    = USED_W'(4);
   localparam logic [MINUTE_W-1:0] CLOSE_RESET = MINUTE_W'(17 * 60);
   localparam logic [MINUTE_W-1:0] MINUTE_MAX  = '1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOWS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSING = 2'd2;

   // Request operations
   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_CLEAR   = 1'b1;

   // Dispatch modes
   localparam logic MODE_FEWEST   = 1'b0;
   localparam logic MODE_EARLIEST = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_SERVED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_QUEUED  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CLOSED  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

   typedef struct packed {
      logic                 op;
      logic [MINUTE_W-1:0]  arrival_minute;
      logic [SERVICE_W-1:0] service_minutes;
   } req_type;

   typedef struct packed {
      logic [WINDOW_W-1:0] window;
      logic [MINUTE_W-1:0] wait_minutes;
      logic [MINUTE_W-1:0] start_minute;
      logic [MINUTE_W-1:0] finish_minute;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RET_RD,
      S_RET_CMP,
      S_SEL_RD,
      S_SEL_CMP,
      S_DONE
   } state_type;

endpackage

@@ design/multi_window_customer_dispatcher_unit.sv @@
// Multi-window customer dispatcher: per-window FIFOs of finish minutes in one RAM.
// Depends on mwcd_pkg.
//
// Usage:
//   Request channel: drive req_data and raise start; the request is taken at a
//   clock edge where start is high and busy is low. op clear empties all
//   windows in that same edge and gives no result. An arrival gives exactly one
//   result: rsp_valid is high for one cycle with rsp_data, and the receiver
//   must take it then (it cannot stall).
//   CSR channel: csr_ready is always high; write mode, window count and
//   closing minute only while the block is idle.
//   Timing: an arrival runs a retire pass over all WINDOWS windows, popping
//   every entry whose finish minute is at or before the arrival minute, then
//   a select pass that stops at the first empty window in use or at the last
//   window in use, then a done state that registers the result. The length
//   of a dispatch is set by the single read port of the finish-time RAM,
//   which is read once per window front, once per retired entry and once per
//   window tail.
//   Throughput: busy drops in the cycle of the result strobe, so the next
//   request can be taken at the edge that takes the result; a clear does not make the block busy.
//   Reset: synchronous; all windows are empty, configuration registers take their defaults.
module multi_window_customer_dispatcher_unit
   import mwcd_pkg::*;
#(
   parameter int WINDOWS     = DEFAULT_WINDOWS,
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int WIN_W  = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
   localparam int HEAD_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int SLOTS  = WINDOWS * QUEUE_DEPTH;
   localparam int ADDR_W = $clog2(SLOTS);
   localparam int LIM_W  = USED_W + 1;

   // Control state
   state_type state_ff, state_in;
   logic [WIN_W-1:0]  win_ff;
   logic [HEAD_W-1:0] head_ff  [WINDOWS];
   logic [CNT_W-1:0]  count_ff [WINDOWS];

   // Configuration
   logic                mode_ff;
   logic [USED_W-1:0]   used_ff;
   logic [MINUTE_W-1:0] closing_ff;

   // Per-request working registers
   logic [MINUTE_W-1:0]  arrival_ff;
   logic [SERVICE_W-1:0] service_ff;
   logic                 found_ff;
   logic [WIN_W-1:0]     best_ff;
   logic [CNT_W-1:0]     best_count_ff;
   logic [HEAD_W-1:0]    best_head_ff;
   logic [MINUTE_W-1:0]  best_tail_ff;

   // Finish-time RAM
   logic [MINUTE_W-1:0] mem [SLOTS];
   logic [MINUTE_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ADDR_W-1:0]   wr_addr;
   logic                mem_we;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   // Window currently addressed by the scan
   logic [HEAD_W-1:0] cur_head;
   logic [CNT_W-1:0]  cur_count;
   logic [HEAD_W-1:0] head_next;
   logic [SUM_W-1:0]  tail_sum;
   logic [HEAD_W-1:0] tail_idx;
   logic [SUM_W-1:0]  wr_sum;
   logic [HEAD_W-1:0] wr_idx;
   logic              accept;
   logic              do_clear;
   logic              pop;
   logic              last_all;
   logic              last_used;
   logic              better;
   logic [LIM_W-1:0]  used_eff;

   // Result arithmetic
   logic [MINUTE_W-1:0] start_min;
   logic [MINUTE_W:0]   finish_sum;
   logic [MINUTE_W-1:0] finish_min;
   logic [MINUTE_W-1:0] wait_min;
   logic                refuse_closed;
   logic                refuse_full;
   logic [STATUS_W-1:0] status;

   assign accept    = start && !busy;
   assign do_clear  = accept && (req_data.op == OP_CLEAR);
   assign csr_ready = 1'b1;

   assign cur_head  = head_ff[win_ff];
   assign cur_count = count_ff[win_ff];
   assign head_next = (cur_head == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;

   // Tail slot of the addressed window: (head + count - 1) mod depth, or head when empty
   assign tail_sum = (cur_count == '0) ? SUM_W'(cur_head)
                                       : SUM_W'(cur_head) + SUM_W'(cur_count) - SUM_W'(1);
   assign tail_idx = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                     HEAD_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : HEAD_W'(tail_sum);

   // Append slot of the chosen window: (head + count) mod depth
   assign wr_sum = SUM_W'(best_head_ff) + SUM_W'(best_count_ff);
   assign wr_idx = (wr_sum >= SUM_W'(QUEUE_DEPTH)) ?
                   HEAD_W'(wr_sum - SUM_W'(QUEUE_DEPTH)) : HEAD_W'(wr_sum);
   assign wr_addr = ADDR_W'(best_ff) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(wr_idx);

   // Clamp the window count to 1..WINDOWS
   always_comb begin
      if (used_ff == '0) begin
         used_eff = LIM_W'(1);
      end else if (LIM_W'(used_ff) > LIM_W'(WINDOWS)) begin
         used_eff = LIM_W'(WINDOWS);
      end else begin
         used_eff = LIM_W'(used_ff);
      end
   end

   assign pop       = (cur_count != '0) && (rd_data_ff <= arrival_ff);
   assign last_all  = (win_ff == WIN_W'(WINDOWS - 1));
   assign last_used = (LIM_W'(win_ff) == used_eff - LIM_W'(1));
   assign better    = (mode_ff == MODE_EARLIEST) ? (rd_data_ff < best_tail_ff)
                                                 : (cur_count < best_count_ff);

   // Start, wait, finish and status of the chosen window
   assign start_min     = found_ff ? arrival_ff : best_tail_ff;
   assign wait_min      = (start_min >= arrival_ff) ? start_min - arrival_ff : '0;
   assign finish_sum    = (MINUTE_W + 1)'(start_min) + (MINUTE_W + 1)'(service_ff);
   assign finish_min    = finish_sum[MINUTE_W] ? MINUTE_MAX : finish_sum[MINUTE_W-1:0];
   assign refuse_closed = (start_min >= closing_ff);
   assign refuse_full   = (best_count_ff >= CNT_W'(QUEUE_DEPTH));

   always_comb begin
      if (refuse_closed) begin
         status = STATUS_CLOSED;
      end else if (refuse_full) begin
         status = STATUS_FULL;
      end else if (found_ff) begin
         status = STATUS_SERVED;
      end else begin
         status = STATUS_QUEUED;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_data.op == OP_ARRIVAL) state_in = S_RET_RD;
         end
         S_RET_RD:  state_in = S_RET_CMP;
         S_RET_CMP: begin
            if (pop || !last_all) state_in = S_RET_RD;
            else state_in = S_SEL_RD;
         end
         S_SEL_RD:  state_in = S_SEL_CMP;
         S_SEL_CMP: begin
            if (cur_count == '0 || last_used) state_in = S_DONE;
            else state_in = S_SEL_RD;
         end
         S_DONE:    state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // FSM outputs: busy, RAM read address and write enable
   always_comb begin
      busy    = 1'b1;
      mem_we  = 1'b0;
      rd_addr = ADDR_W'(win_ff) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(cur_head);
      case (state_ff)
         S_IDLE:    busy = 1'b0;
         S_RET_RD:  ;
         S_RET_CMP: ;
         S_SEL_RD:  rd_addr = ADDR_W'(win_ff) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_idx);
         S_SEL_CMP: ;
         S_DONE:    mem_we = !refuse_closed && !refuse_full;
         default:   busy = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_RESET;
         used_ff    <= USED_RESET;
         closing_ff <= CLOSE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MODE:    mode_ff    <= csr_wdata[0];
            CSR_WINDOWS: used_ff    <= csr_wdata[USED_W-1:0];
            CSR_CLOSING: closing_ff <= csr_wdata[MINUTE_W-1:0];
            default:     ;
         endcase
      end
   end

   // Window scan counter
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE:    win_ff <= '0;
            S_RET_CMP: begin
               if (!pop) win_ff <= last_all ? '0 : win_ff + 1'b1;
            end
            S_SEL_CMP: win_ff <= win_ff + 1'b1;
            default:   ;
         endcase
      end
   end

   // Head pointers and entry counts
   always_ff @(posedge clock) begin
      if (reset || do_clear) begin
         for (int w = 0; w < WINDOWS; w++) begin
            head_ff[w]  <= '0;
            count_ff[w] <= '0;
         end
      end else if (state_ff == S_RET_CMP && pop) begin
         head_ff[win_ff]  <= head_next;
         count_ff[win_ff] <= cur_count - 1'b1;
      end else if (mem_we) begin
         count_ff[best_ff] <= best_count_ff + 1'b1;
      end
   end

   // Request capture and best-window tracking
   always_ff @(posedge clock) begin
      if (accept) begin
         arrival_ff <= req_data.arrival_minute;
         service_ff <= req_data.service_minutes;
         found_ff   <= 1'b0;
      end else if (state_ff == S_SEL_CMP) begin
         if (cur_count == '0) begin
            found_ff      <= 1'b1;
            best_ff       <= win_ff;
            best_count_ff <= '0;
            best_head_ff  <= cur_head;
         end else if (win_ff == '0 || better) begin
            best_ff       <= win_ff;
            best_count_ff <= cur_count;
            best_head_ff  <= cur_head;
            best_tail_ff  <= rd_data_ff;
         end
      end
   end

   // Finish-time RAM, one read and one write port
   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= finish_min;
      rd_data_ff <= mem[rd_addr];
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == S_DONE);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE) begin
         rsp_data_ff.window        <= WINDOW_W'(best_ff);
         rsp_data_ff.wait_minutes  <= wait_min;
         rsp_data_ff.start_minute  <= start_min;
         rsp_data_ff.finish_minute <= finish_min;
         rsp_data_ff.status        <= status;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_DONE))
      else $error("result strobe without a finished dispatch");

   a_arrival_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.op == OP_ARRIVAL) |=> busy)
      else $error("accepted arrival did not start a dispatch");

   a_served_no_wait: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_SERVED) |-> rsp_data.wait_minutes == '0)
      else $error("immediate service reported a wait");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cur_count <= CNT_W'(QUEUE_DEPTH))
      else $error("window entry count above queue depth");

endmodule
